// ===== src/tiw_pkg.sv =====
// package: widths, constants, register indexes and stage control type for the idf weight block
`timescale 1ns / 1ps
package tiw_pkg;
  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int LOG_FRAC    = 30;
  localparam int LN2_W       = 24;
  localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
  localparam int OUT_W       = 22;
  localparam int X_W         = COUNT_WIDTH + 2;
  localparam int E_W         = $clog2(X_W);
  localparam int L_W         = E_W + LOG_FRAC;
  localparam int P_W         = L_W + LN2_W;
  localparam int RND_BM25    = LOG_FRAC - FRAC_BITS;
  localparam int RND_LN      = LOG_FRAC + LN2_W - FRAC_BITS;
  localparam int ADDR_W      = 3;

  localparam logic REG_COLLECTION = 1'b0;
  localparam logic REG_MODE       = 1'b1;
  localparam logic MODE_BM25      = 1'b0;
  localparam logic MODE_LN        = 1'b1;

  typedef struct packed {
    logic df_zero;
    logic n_zero;
    logic mode;
  } tiw_ctl_t;
endpackage

// ===== src/term_idf_weight.sv =====
// top level: idf weight of one term, bm25 log2 or natural-log mode, fully pipelined
// path: an accepted word passes s1, stage 0, the squaring stages, then the difference, scale and done registers
// throughput: one word per cycle, every stage takes a new word each cycle
// busy is never raised; the receiver cannot stall, so results just fall out in order
// reset clears the valid bits and sets collection_size to 1, weight_mode to bm25
`timescale 1ns / 1ps
module term_idf_weight (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] doc_freq,
  output logic        done,
  output logic signed [21:0] idf_weight,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [tiw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tiw_pkg::*;

  // configuration registers
  logic [31:0] collection_size;
  logic        weight_mode;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      collection_size <= 32'd1;
      weight_mode     <= MODE_BM25;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_COLLECTION: collection_size <= pwdata;
        REG_MODE:       weight_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COLLECTION: prdata = collection_size;
      REG_MODE:       prdata = {31'd0, weight_mode};
      default:        prdata = 32'd0;
    endcase
  end

  // operand build: bm25 uses log2(2n+2) - log2(2df+1), ln mode log2(n) - log2(df)
  logic [COUNT_WIDTH-1:0] nc, dfc;
  logic [X_W-1:0] xa_in, xb_in;
  assign nc  = COUNT_WIDTH'(collection_size);
  assign dfc = COUNT_WIDTH'(doc_freq);
  always_comb begin
    if (weight_mode == MODE_LN) begin
      xa_in = X_W'(nc);
      xb_in = X_W'(dfc);
    end else begin
      xa_in = (X_W'(nc) << 1) + X_W'(2);
      xb_in = (X_W'(dfc) << 1) + X_W'(1);
    end
  end

  // stage s1: operands registered at accept
  logic           s1_vld;
  logic [X_W-1:0] s1_xa, s1_xb;
  tiw_ctl_t       s1_ctl;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start;
    s1_xa          <= xa_in;
    s1_xb          <= xb_in;
    s1_ctl.df_zero <= (dfc == '0);
    s1_ctl.n_zero  <= (nc == '0);
    s1_ctl.mode    <= weight_mode;
  end

  // leading-one position
  function automatic logic [E_W-1:0] lead_one(input logic [X_W-1:0] x);
    logic [E_W-1:0] e;
    e = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) e = E_W'(i);
    end
    return e;
  endfunction

  logic [E_W-1:0] ea_n, eb_n;
  logic [X_W+LOG_FRAC-1:0] sha, shb;
  assign ea_n = lead_one(s1_xa);
  assign eb_n = lead_one(s1_xb);
  // mantissa to q1.30, low bits truncated
  assign sha  = {s1_xa, LOG_FRAC'(0)} >> ea_n;
  assign shb  = {s1_xb, LOG_FRAC'(0)} >> eb_n;

  // squaring chain: stage 0 holds the normalized mantissa, stage k has k fraction bits
  logic                vld [0:LOG_FRAC];
  tiw_ctl_t            ctl [0:LOG_FRAC];
  logic [E_W-1:0]      ea  [0:LOG_FRAC];
  logic [E_W-1:0]      eb  [0:LOG_FRAC];
  logic [LOG_FRAC:0]   ma  [0:LOG_FRAC];
  logic [LOG_FRAC:0]   mb  [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fa  [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fb  [0:LOG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= s1_vld;
    ctl[0] <= s1_ctl;
    ea[0]  <= ea_n;
    eb[0]  <= eb_n;
    ma[0]  <= sha[LOG_FRAC:0];
    mb[0]  <= shb[LOG_FRAC:0];
    fa[0]  <= '0;
    fb[0]  <= '0;
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    logic [2*LOG_FRAC+1:0] pa, pb;
    logic [LOG_FRAC+1:0]   ta, tb;
    assign pa = ma[k] * ma[k];
    assign pb = mb[k] * mb[k];
    assign ta = pa[2*LOG_FRAC+1:LOG_FRAC];
    assign tb = pb[2*LOG_FRAC+1:LOG_FRAC];

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
      ctl[k+1] <= ctl[k];
      ea[k+1]  <= ea[k];
      eb[k+1]  <= eb[k];
      // square reached 2.0: halve and emit a one
      ma[k+1]  <= ta[LOG_FRAC+1] ? ta[LOG_FRAC+1:1] : ta[LOG_FRAC:0];
      mb[k+1]  <= tb[LOG_FRAC+1] ? tb[LOG_FRAC+1:1] : tb[LOG_FRAC:0];
      fa[k+1]  <= {fa[k][LOG_FRAC-2:0], ta[LOG_FRAC+1]};
      fb[k+1]  <= {fb[k][LOG_FRAC-2:0], tb[LOG_FRAC+1]};
    end
  end

  // difference stage: sign and magnitude of log2(a) - log2(b)
  logic [L_W-1:0] la, lb;
  assign la = {ea[LOG_FRAC], fa[LOG_FRAC]};
  assign lb = {eb[LOG_FRAC], fb[LOG_FRAC]};

  logic           d_vld, d_neg;
  tiw_ctl_t       d_ctl;
  logic [L_W-1:0] d_mag;

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else     d_vld <= vld[LOG_FRAC];
    d_ctl <= ctl[LOG_FRAC];
    d_neg <= (lb > la);
    d_mag <= (lb > la) ? lb - la : la - lb;
  end

  // scale stage: times ln2 in natural-log mode
  logic           p_vld, p_neg;
  tiw_ctl_t       p_ctl;
  logic [P_W-1:0] p_mag;

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else     p_vld <= d_vld;
    p_ctl <= d_ctl;
    p_neg <= d_neg;
    if (d_ctl.mode == MODE_LN) p_mag <= P_W'(d_mag) * P_W'(LN2_Q24);
    else                       p_mag <= P_W'(d_mag);
  end

  // round half away from zero, then saturate; df zero gives 0, n zero in ln mode the most negative value
  logic [P_W:0]     rsum, rr;
  logic [OUT_W-1:0] rsat;
  localparam logic [P_W:0] POS_MAX = (P_W+1)'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [P_W:0] NEG_MAG = (P_W+1)'(64'd1 << (OUT_W - 1));

  always_comb begin
    if (p_ctl.mode == MODE_LN) begin
      rsum = (P_W+1)'(p_mag) + ((P_W+1)'(1) << (RND_LN - 1));
      rr   = rsum >> RND_LN;
    end else begin
      rsum = (P_W+1)'(p_mag) + ((P_W+1)'(1) << (RND_BM25 - 1));
      rr   = rsum >> RND_BM25;
    end
    if (p_ctl.df_zero) begin
      rsat = '0;
    end else if (p_ctl.mode == MODE_LN && p_ctl.n_zero) begin
      rsat = OUT_W'(NEG_MAG);
    end else if (p_neg) begin
      rsat = (rr > NEG_MAG) ? OUT_W'(NEG_MAG) : OUT_W'(~rr + 1'b1);
    end else begin
      rsat = (rr > POS_MAX) ? OUT_W'(POS_MAX) : OUT_W'(rr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= p_vld;
    idf_weight <= $signed(rsat);
  end
endmodule
